### rtl/ptt_pkg.sv
// Shared types, constants and helpers for the perceptron trainer.
package ptt_pkg;

    localparam int TRAIN_DEPTH_DEF   = 128;
    localparam int TEST_DEPTH_DEF    = 128;
    localparam int FEATURE_COUNT_DEF = 4;
    localparam int FEAT_W            = 16;
    localparam int WEIGHT_W          = 32;
    localparam int CFG_ADDR_W        = 3;
    localparam int CFG_DATA_W        = 32;
    localparam int SUM_W             = 52;
    localparam int STEP_W            = 34;
    localparam int IN_DATA_W         = 72;
    localparam int OUT_DATA_W        = 32;
    localparam int QUEUE_DEPTH       = 4;
    localparam int QUEUE_PTR_W       = 2;

    typedef enum logic [1:0] {
        CMD_LOAD_TRAIN = 2'd0,
        CMD_LOAD_TEST  = 2'd1,
        CMD_RUN        = 2'd2,
        CMD_CLEAR      = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_LEARNING_RATE = 3'd0,
        REG_EPOCH_COUNT   = 3'd1,
        REG_START_WEIGHT_A = 3'd2,
        REG_START_WEIGHT_B = 3'd3,
        REG_START_WEIGHT_C = 3'd4,
        REG_START_WEIGHT_D = 3'd5,
        REG_START_OFFSET  = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_TRAIN,
        ST_TEST,
        ST_DONE
    } eng_state_t;

    typedef struct packed {
        logic [3:0][FEAT_W-1:0] feat;
        logic                   label;
    } sample_t;

    typedef struct packed {
        cmd_t    cmd;
        sample_t smp;
    } queue_item_t;

    function automatic logic signed [WEIGHT_W-1:0] sat32(input logic signed [STEP_W:0] v);
        logic signed [STEP_W:0] hi;
        logic signed [STEP_W:0] lo;
        hi = (STEP_W+1)'(signed'(33'sh0_7FFF_FFFF));
        lo = -(STEP_W+1)'(signed'(33'sh0_8000_0000));
        if (v > hi) return 32'sh7FFF_FFFF;
        if (v < lo) return 32'sh8000_0000;
        return v[WEIGHT_W-1:0];
    endfunction

endpackage

### rtl/ptt_front.sv
// Input acceptance and command queue ahead of the training engine.
module ptt_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ptt_pkg::queue_item_t in_item,
    output logic                 q_valid,
    input  logic                 q_ready,
    output ptt_pkg::queue_item_t q_item
);
    ptt_pkg::queue_item_t mem_reg [ptt_pkg::QUEUE_DEPTH];
    logic [ptt_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [ptt_pkg::QUEUE_PTR_W:0]   count_reg;
    logic push, pop;

    assign in_ready = (count_reg != (ptt_pkg::QUEUE_PTR_W+1)'(ptt_pkg::QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (ptt_pkg::QUEUE_PTR_W+1)'(push)
                                   - (ptt_pkg::QUEUE_PTR_W+1)'(pop);
        end
    end
endmodule

### rtl/ptt_engine.sv
// Sample stores, perceptron training and test scoring.
module ptt_engine #(
    parameter int TRAIN_DEPTH   = ptt_pkg::TRAIN_DEPTH_DEF,
    parameter int TEST_DEPTH    = ptt_pkg::TEST_DEPTH_DEF,
    parameter int FEATURE_COUNT = ptt_pkg::FEATURE_COUNT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  ptt_pkg::queue_item_t q_item,
    input  logic [15:0]          learning_rate,
    input  logic [9:0]           epoch_count,
    input  logic [3:0][31:0]     start_weight,
    input  logic [31:0]          start_offset,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic [ptt_pkg::OUT_DATA_W-1:0] res_data
);
    localparam int TRA_W  = (TRAIN_DEPTH > 1) ? $clog2(TRAIN_DEPTH) : 1;
    localparam int TEA_W  = (TEST_DEPTH > 1) ? $clog2(TEST_DEPTH) : 1;
    localparam int TRC_W  = $clog2(TRAIN_DEPTH + 1);
    localparam int TEC_W  = $clog2(TEST_DEPTH + 1);
    localparam int PW     = 48;

    ptt_pkg::sample_t train_mem [TRAIN_DEPTH];
    ptt_pkg::sample_t test_mem  [TEST_DEPTH];

    ptt_pkg::eng_state_t state_reg, state_next;
    logic [TRC_W-1:0] train_fill_reg;
    logic [TEC_W-1:0] test_fill_reg;
    logic             dropped_reg;
    logic [3:0][31:0] weight_reg;
    logic [31:0]      bias_reg;
    logic [9:0]       epoch_reg;
    logic [TRC_W-1:0] tr_idx_reg;
    logic [TEC_W-1:0] te_idx_reg;
    logic [7:0]       correct_reg;
    // pipeline: phase 0 read issued, 1 data valid (multiply), 2 sum, 3 update
    logic [1:0]       phase_reg;
    ptt_pkg::sample_t rd_reg;
    logic signed [PW-1:0] prod_reg [4];
    logic signed [ptt_pkg::STEP_W-1:0] step_reg [4];
    logic             pred_reg;
    logic             res_valid_reg;
    logic [ptt_pkg::OUT_DATA_W-1:0] res_data_reg;

    logic accept;
    logic idle_take;
    logic signed [ptt_pkg::SUM_W-1:0] sum;
    logic tr_last, te_last;

    assign idle_take = (state_reg == ptt_pkg::ST_IDLE) && !res_valid_reg;
    assign q_ready   = idle_take;
    assign accept    = q_valid && idle_take;
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;
    assign tr_last   = (tr_idx_reg + 1'b1 == train_fill_reg);
    assign te_last   = (te_idx_reg + 1'b1 == test_fill_reg);

    always_comb begin
        sum = {{(ptt_pkg::SUM_W-40){bias_reg[31]}}, bias_reg, 8'd0};
        for (int i = 0; i < 4; i++) begin
            if (i < FEATURE_COUNT) begin
                sum = sum + ptt_pkg::SUM_W'(prod_reg[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && q_item.cmd == ptt_pkg::CMD_LOAD_TRAIN
            && train_fill_reg < TRC_W'(TRAIN_DEPTH)) begin
            train_mem[train_fill_reg[TRA_W-1:0]] <= q_item.smp;
        end
        if (accept && q_item.cmd == ptt_pkg::CMD_LOAD_TEST
            && test_fill_reg < TEC_W'(TEST_DEPTH)) begin
            test_mem[test_fill_reg[TEA_W-1:0]] <= q_item.smp;
        end
        if (state_reg == ptt_pkg::ST_TRAIN) begin
            rd_reg <= train_mem[tr_idx_reg[TRA_W-1:0]];
        end else begin
            rd_reg <= test_mem[te_idx_reg[TEA_W-1:0]];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ptt_pkg::ST_IDLE:  if (accept && q_item.cmd == ptt_pkg::CMD_RUN)
                                   state_next = ptt_pkg::ST_INIT;
            ptt_pkg::ST_INIT: begin
                if (epoch_count != '0 && train_fill_reg != '0) state_next = ptt_pkg::ST_TRAIN;
                else if (test_fill_reg != '0) state_next = ptt_pkg::ST_TEST;
                else state_next = ptt_pkg::ST_DONE;
            end
            ptt_pkg::ST_TRAIN: if (phase_reg == 2'd3 && tr_last && epoch_reg == 10'd1) begin
                state_next = (test_fill_reg != '0) ? ptt_pkg::ST_TEST : ptt_pkg::ST_DONE;
            end
            ptt_pkg::ST_TEST:  if (phase_reg == 2'd3 && te_last) state_next = ptt_pkg::ST_DONE;
            ptt_pkg::ST_DONE:  state_next = ptt_pkg::ST_IDLE;
            default:           state_next = ptt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 4; i++) begin
            prod_reg[i] <= PW'($signed(weight_reg[i])) * PW'($signed(rd_reg.feat[i]));
            step_reg[i] <= ptt_pkg::STEP_W'((($signed({1'b0, learning_rate})
                           * $signed(rd_reg.feat[i])) + 34'sd128) >>> 8);
        end
        if (phase_reg == 2'd2) pred_reg <= !sum[ptt_pkg::SUM_W-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ptt_pkg::ST_IDLE;
            train_fill_reg <= '0;
            test_fill_reg  <= '0;
            dropped_reg    <= 1'b0;
            weight_reg     <= '0;
            bias_reg       <= '0;
            epoch_reg      <= '0;
            tr_idx_reg     <= '0;
            te_idx_reg     <= '0;
            correct_reg    <= '0;
            phase_reg      <= '0;
            res_valid_reg  <= 1'b0;
            res_data_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (res_valid_reg && res_ready) res_valid_reg <= 1'b0;
            if (accept) begin
                unique case (q_item.cmd)
                    ptt_pkg::CMD_LOAD_TRAIN:
                        if (train_fill_reg < TRC_W'(TRAIN_DEPTH)) train_fill_reg <= train_fill_reg + 1'b1;
                        else dropped_reg <= 1'b1;
                    ptt_pkg::CMD_LOAD_TEST:
                        if (test_fill_reg < TEC_W'(TEST_DEPTH)) test_fill_reg <= test_fill_reg + 1'b1;
                        else dropped_reg <= 1'b1;
                    ptt_pkg::CMD_CLEAR: begin
                        train_fill_reg <= '0;
                        test_fill_reg  <= '0;
                        dropped_reg    <= 1'b0;
                    end
                    default: ;
                endcase
            end
            unique case (state_reg)
                ptt_pkg::ST_INIT: begin
                    weight_reg  <= start_weight;
                    bias_reg    <= start_offset;
                    epoch_reg   <= epoch_count;
                    tr_idx_reg  <= '0;
                    te_idx_reg  <= '0;
                    correct_reg <= '0;
                    phase_reg   <= '0;
                end
                ptt_pkg::ST_TRAIN: begin
                    phase_reg <= phase_reg + 1'b1;
                    if (phase_reg == 2'd3) begin
                        if (pred_reg != rd_reg.label) begin
                            for (int i = 0; i < 4; i++) begin
                                if (i < FEATURE_COUNT) begin
                                    weight_reg[i] <= ptt_pkg::sat32(rd_reg.label
                                        ? (ptt_pkg::STEP_W+1)'($signed(weight_reg[i])) + (ptt_pkg::STEP_W+1)'(step_reg[i])
                                        : (ptt_pkg::STEP_W+1)'($signed(weight_reg[i])) - (ptt_pkg::STEP_W+1)'(step_reg[i]));
                                end
                            end
                            bias_reg <= ptt_pkg::sat32(rd_reg.label
                                ? (ptt_pkg::STEP_W+1)'($signed(bias_reg)) + (ptt_pkg::STEP_W+1)'({1'b0, learning_rate})
                                : (ptt_pkg::STEP_W+1)'($signed(bias_reg)) - (ptt_pkg::STEP_W+1)'({1'b0, learning_rate}));
                        end
                        if (tr_last) begin
                            tr_idx_reg <= '0;
                            epoch_reg  <= epoch_reg - 1'b1;
                        end else begin
                            tr_idx_reg <= tr_idx_reg + 1'b1;
                        end
                    end
                end
                ptt_pkg::ST_TEST: begin
                    phase_reg <= phase_reg + 1'b1;
                    if (phase_reg == 2'd3) begin
                        if (pred_reg == rd_reg.label) correct_reg <= correct_reg + 1'b1;
                        te_idx_reg <= te_idx_reg + 1'b1;
                    end
                end
                ptt_pkg::ST_DONE: begin
                    res_valid_reg <= 1'b1;
                    res_data_reg  <= {7'd0, dropped_reg, 8'(train_fill_reg),
                                      8'(test_fill_reg), correct_reg};
                end
                default: ;
            endcase
        end
    end
endmodule

### rtl/perceptron_train_and_test.sv
// Top level of the perceptron trainer: ports, register file, front queue and engine.
//
// Usage: s_axis_* carries commands with a sample (load train, load test, run,
// clear). Loads and clears produce no result. A run produces one result on
// m_axis_* with correct, tested and trained counts and the overflow flag.
// Loads and clears pass a four-entry queue, and a burst of loads streams
// at one per cycle while the engine is idle and holds no result. During a
// run each sample goes through a store read, a multiply stage, the sum and
// sign, and the weight update (or the score, for a test sample), and the
// next sample waits on that last step.
// Reset clears fills, flag, weights and bias; store contents stay unknown
// until written and are never used past the fill counts.
// A stalled receiver holds the result in its output register; the engine
// takes no new command until it is transferred, while the queue still
// accepts up to four more transfers.
// Configuration writes through cfg_* are taken at any edge with cfg_we high
// and must happen while idle.
module perceptron_train_and_test #(
    parameter int TRAIN_DEPTH   = ptt_pkg::TRAIN_DEPTH_DEF,
    parameter int TEST_DEPTH    = ptt_pkg::TEST_DEPTH_DEF,
    parameter int FEATURE_COUNT = ptt_pkg::FEATURE_COUNT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // command[1:0], feature_a[17:2], feature_b[33:18], feature_c[49:34],
    // feature_d[65:50], label[66], zero fill to 72
    input  logic [ptt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // correct_count[7:0], tested_count[15:8], trained_count[23:16],
    // overflow_seen[24], zero fill to 32
    output logic [ptt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                             cfg_we,
    input  logic [ptt_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [ptt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    logic [15:0]      lr_reg;
    logic [9:0]       epochs_reg;
    logic [3:0][31:0] start_w_reg;
    logic [31:0]      start_b_reg;

    ptt_pkg::queue_item_t in_item, q_item;
    logic q_valid, q_ready;

    // Unpack the sample; feature slots are stored in index order.
    assign in_item.cmd          = ptt_pkg::cmd_t'(s_axis_tdata[1:0]);
    assign in_item.smp.feat[0]  = s_axis_tdata[17:2];
    assign in_item.smp.feat[1]  = s_axis_tdata[33:18];
    assign in_item.smp.feat[2]  = s_axis_tdata[49:34];
    assign in_item.smp.feat[3]  = s_axis_tdata[65:50];
    assign in_item.smp.label    = s_axis_tdata[66];

    // Configuration register file.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lr_reg      <= 16'd6554;
            epochs_reg  <= 10'd100;
            start_w_reg <= '0;
            start_b_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                ptt_pkg::REG_LEARNING_RATE:  lr_reg         <= cfg_wdata[15:0];
                ptt_pkg::REG_EPOCH_COUNT:    epochs_reg     <= cfg_wdata[9:0];
                ptt_pkg::REG_START_WEIGHT_A: start_w_reg[0] <= cfg_wdata;
                ptt_pkg::REG_START_WEIGHT_B: start_w_reg[1] <= cfg_wdata;
                ptt_pkg::REG_START_WEIGHT_C: start_w_reg[2] <= cfg_wdata;
                ptt_pkg::REG_START_WEIGHT_D: start_w_reg[3] <= cfg_wdata;
                ptt_pkg::REG_START_OFFSET:   start_b_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    ptt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    ptt_engine #(
        .TRAIN_DEPTH   (TRAIN_DEPTH),
        .TEST_DEPTH    (TEST_DEPTH),
        .FEATURE_COUNT (FEATURE_COUNT)
    ) u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item),
        .learning_rate (lr_reg),
        .epoch_count   (epochs_reg),
        .start_weight  (start_w_reg),
        .start_offset  (start_b_reg),
        .res_valid     (m_axis_tvalid),
        .res_ready     (m_axis_tready),
        .res_data      (m_axis_tdata)
    );
endmodule
